>>> design/flat_face_normal_engine_defines.svh
// Assertion macros for the flat-shading face normal engine checker.
// Included by the checker file; no other dependencies.
`ifndef FLAT_FACE_NORMAL_ENGINE_DEFINES_SVH
`define FLAT_FACE_NORMAL_ENGINE_DEFINES_SVH

// Check a property on the rising clock, skipped while reset is asserted.
`define FFN_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock, including reset cycles.
`define FFN_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/ffn_pkg.sv
// Types and constants shared by the face normal engine and its checker.
// No dependencies.
package ffn_pkg;

    localparam int INDEX_W = 10;
    localparam int COORD_W = 16;
    localparam int POS_W   = 3 * COORD_W;
    localparam int DIFF_W  = 17;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 36;
    localparam int CROSS_W = 35;
    localparam int MAG_W   = 34;
    localparam int SQ_W    = 68;
    localparam int REM_W   = 69;
    localparam int QUO_W   = 29;
    localparam int ROOT_W  = 15;
    localparam int NORM_W  = 16;
    localparam int CNT_W   = 5;

    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_TRIANGLE = 1'b1;

    localparam logic [CNT_W-1:0] READ_LAST  = CNT_W'(3);
    localparam logic [CNT_W-1:0] CROSS_LAST = CNT_W'(6);
    localparam logic [CNT_W-1:0] SQ_LAST    = CNT_W'(9);
    localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST  = CNT_W'(ROOT_W - 1);

    localparam logic [1:0] LAST_CORNER = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DIFF,
        S_CROSS,
        S_MAG,
        S_SQ,
        S_DINIT,
        S_DIV,
        S_SQRT,
        S_OUT
    } t_state;

endpackage

>>> design/flat_face_normal_engine.sv
// Flat-shading face normal engine: vertex store, cross product, normalization.
// Throughput: vertex writes are taken every cycle while no triangle is in progress.
// Triangle: one shared 18x18 multiplier does the cross product, squares and roots;
// then a 29-step divider and 15-step square root per component; degenerate skips both.
// Three results follow, one per output transfer; the next item is taken after the last.
// Reset (i_rst_n low, synchronous) clears control state; the store stays undefined.
module flat_face_normal_engine import ffn_pkg::*; #(
    parameter int VERTEX_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [INDEX_W-1:0]        i_write_index,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic [INDEX_W-1:0]        i_corner_a,
    input  logic [INDEX_W-1:0]        i_corner_b,
    input  logic [INDEX_W-1:0]        i_corner_c,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [INDEX_W-1:0]        o_target_vertex,
    output logic signed [NORM_W-1:0]  o_normal_x,
    output logic signed [NORM_W-1:0]  o_normal_y,
    output logic signed [NORM_W-1:0]  o_normal_z,
    output logic                      o_degenerate,
    output logic                      o_last
);

    localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [1:0]                 r_ci, n_ci;
    logic [1:0]                 r_k, n_k;

    logic [POS_W-1:0]           r_mem [VERTEX_DEPTH];
    logic [POS_W-1:0]           r_rdata;
    logic                       r_rd_ok;

    logic [INDEX_W-1:0]         r_corner [3];
    logic [POS_W-1:0]           r_pos [3];
    logic signed [DIFF_W-1:0]   r_d1 [3];
    logic signed [DIFF_W-1:0]   r_d2 [3];
    logic signed [PROD_W-1:0]   r_prod;
    logic [3:0]                 r_tag;
    logic signed [CROSS_W-1:0]  r_n [3];
    logic [MAG_W-1:0]           r_m [3];
    logic [2:0]                 r_neg;
    logic [SQ_W-1:0]            r_sq [3];
    logic [SQ_W-1:0]            r_len2;
    logic [REM_W-1:0]           r_rem;
    logic [QUO_W-1:0]           r_nlo;
    logic [QUO_W-1:0]           r_quo;
    logic [ROOT_W-1:0]          r_root;
    logic [NORM_W-1:0]          r_norm [3];
    logic                       r_degen;

    logic                       in_fire;
    logic                       wr_ok;
    logic [AW-1:0]              wr_addr;
    logic [1:0]                 sel_idx;
    logic [INDEX_W-1:0]         corner_sel;
    logic                       rd_en;
    logic                       rd_ok;
    logic [AW-1:0]              rd_addr;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [MAG_W-1:0]           m_sel;
    logic [1:0]                 iss_comp, iss_part, acc_comp, acc_part;
    logic [SQ_W-1:0]            sq_term;
    logic [REM_W-1:0]           div_t;
    logic                       div_ge;
    logic [ROOT_W-1:0]          root_try;
    logic                       sq_ok;
    logic [ROOT_W-1:0]          root_fin;
    logic                       len2_zero;

    function automatic logic [1:0] sq_comp(input logic [3:0] t);
        if (t < 4'd3) begin
            return 2'd0;
        end else if (t < 4'd6) begin
            return 2'd1;
        end
        return 2'd2;
    endfunction

    function automatic logic [1:0] sq_part(input logic [3:0] t);
        logic [1:0] c;
        logic [3:0] r;
        c = sq_comp(t);
        r = t - {1'b0, c, 1'b0} - {2'b0, c};
        return r[1:0];
    endfunction

    assign in_fire    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign wr_ok      = 32'(i_write_index) < 32'(VERTEX_DEPTH);
    assign wr_addr    = AW'(i_write_index);

    assign sel_idx    = (r_state == S_OUT) ? r_k : r_cnt[1:0];
    assign corner_sel = r_corner[sel_idx];
    assign rd_en      = (r_state == S_READ) && (r_cnt != READ_LAST);
    assign rd_ok      = 32'(corner_sel) < 32'(VERTEX_DEPTH);
    assign rd_addr    = AW'(corner_sel);

    assign iss_comp  = sq_comp(r_cnt[3:0]);
    assign iss_part  = sq_part(r_cnt[3:0]);
    assign acc_comp  = sq_comp(r_tag);
    assign acc_part  = sq_part(r_tag);
    assign m_sel     = r_m[iss_comp];
    assign len2_zero = (r_len2 == '0);

    assign div_t  = {r_rem[REM_W-2:0], r_nlo[QUO_W-1]};
    assign div_ge = div_t >= {1'b0, r_len2};

    assign root_try = r_root | (ROOT_W'(1) << (4'(ROOT_W - 1) - r_cnt[3:0]));
    assign sq_ok    = $unsigned(mul_p) <= PROD_W'(r_quo);
    assign root_fin = sq_ok ? root_try : r_root;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_CROSS: begin
                unique case (r_cnt[2:0])
                    3'd0: begin mul_a = MUL_W'(r_d1[1]); mul_b = MUL_W'(r_d2[2]); end
                    3'd1: begin mul_a = MUL_W'(r_d1[2]); mul_b = MUL_W'(r_d2[1]); end
                    3'd2: begin mul_a = MUL_W'(r_d1[2]); mul_b = MUL_W'(r_d2[0]); end
                    3'd3: begin mul_a = MUL_W'(r_d1[0]); mul_b = MUL_W'(r_d2[2]); end
                    3'd4: begin mul_a = MUL_W'(r_d1[0]); mul_b = MUL_W'(r_d2[1]); end
                    3'd5: begin mul_a = MUL_W'(r_d1[1]); mul_b = MUL_W'(r_d2[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SQ: begin
                unique case (iss_part)
                    2'd0: begin
                        mul_a = {1'b0, m_sel[16:0]};
                        mul_b = {1'b0, m_sel[16:0]};
                    end
                    2'd1: begin
                        mul_a = {1'b0, m_sel[16:0]};
                        mul_b = {1'b0, m_sel[33:17]};
                    end
                    default: begin
                        mul_a = {1'b0, m_sel[33:17]};
                        mul_b = {1'b0, m_sel[33:17]};
                    end
                endcase
            end
            S_SQRT: begin
                mul_a = {3'b0, root_try};
                mul_b = {3'b0, root_try};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        unique case (acc_part)
            2'd0:    sq_term = SQ_W'(r_prod[MAG_W-1:0]);
            2'd1:    sq_term = SQ_W'(r_prod[MAG_W-1:0]) << 18;
            default: sq_term = SQ_W'(r_prod[MAG_W-1:0]) << 34;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_command == CMD_WRITE) && wr_ok) begin
            r_mem[wr_addr] <= {i_pos_z, i_pos_y, i_pos_x};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rd_ok <= rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ci    <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ci    <= n_ci;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ci    = r_ci;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_command == CMD_TRIANGLE)) begin
                    n_state = S_READ;
                    n_cnt   = '0;
                end
            end
            S_READ: begin
                if (r_cnt == READ_LAST) begin
                    n_state = S_DIFF;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DIFF: begin
                n_state = S_CROSS;
                n_cnt   = '0;
            end
            S_CROSS: begin
                if (r_cnt == CROSS_LAST) begin
                    n_state = S_MAG;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MAG: begin
                n_state = S_SQ;
                n_cnt   = '0;
            end
            S_SQ: begin
                if (r_cnt == SQ_LAST) begin
                    n_state = S_DINIT;
                    n_cnt   = '0;
                    n_ci    = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DINIT: begin
                n_cnt = '0;
                if (len2_zero) begin
                    n_state = S_OUT;
                    n_k     = '0;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = S_SQRT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                if (r_cnt == SQRT_LAST) begin
                    n_cnt = '0;
                    if (r_ci == LAST_CORNER) begin
                        n_state = S_OUT;
                        n_k     = '0;
                    end else begin
                        n_state = S_DINIT;
                        n_ci    = r_ci + 1'b1;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    if (r_k == LAST_CORNER) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_command == CMD_TRIANGLE)) begin
                    r_corner[0] <= i_corner_a;
                    r_corner[1] <= i_corner_b;
                    r_corner[2] <= i_corner_c;
                end
            end
            S_READ: begin
                if (r_cnt != '0) begin
                    r_pos[2'(r_cnt - 1'b1)] <= r_rd_ok ? r_rdata : '0;
                end
            end
            S_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    r_d1[i] <= DIFF_W'($signed(r_pos[0][COORD_W*i +: COORD_W]))
                             - DIFF_W'($signed(r_pos[2][COORD_W*i +: COORD_W]));
                    r_d2[i] <= DIFF_W'($signed(r_pos[0][COORD_W*i +: COORD_W]))
                             - DIFF_W'($signed(r_pos[1][COORD_W*i +: COORD_W]));
                end
            end
            S_CROSS: begin
                r_prod <= mul_p;
                r_tag  <= r_cnt[3:0];
                if (r_cnt != '0) begin
                    if (!r_tag[0]) begin
                        r_n[r_tag[2:1]] <= CROSS_W'(r_prod);
                    end else begin
                        r_n[r_tag[2:1]] <= r_n[r_tag[2:1]] - CROSS_W'(r_prod);
                    end
                end
            end
            S_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= r_n[i][CROSS_W-1] ? MAG_W'(-r_n[i]) : MAG_W'(r_n[i]);
                    r_neg[i] <= r_n[i][CROSS_W-1];
                    r_sq[i]  <= '0;
                end
                r_len2 <= '0;
            end
            S_SQ: begin
                r_prod <= mul_p;
                r_tag  <= r_cnt[3:0];
                if (r_cnt != '0) begin
                    r_sq[acc_comp] <= r_sq[acc_comp] + sq_term;
                    r_len2         <= r_len2 + sq_term;
                end
            end
            S_DINIT: begin
                r_degen <= len2_zero;
                if (len2_zero) begin
                    for (int i = 0; i < 3; i++) begin
                        r_norm[i] <= '0;
                    end
                end
                r_rem  <= REM_W'(r_sq[r_ci] >> 1);
                r_nlo  <= {r_sq[r_ci][0], {(QUO_W-1){1'b0}}};
                r_quo  <= '0;
                r_root <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? (div_t - {1'b0, r_len2}) : div_t;
                r_nlo <= r_nlo << 1;
                r_quo <= {r_quo[QUO_W-2:0], div_ge};
            end
            S_SQRT: begin
                r_root <= root_fin;
                if (r_cnt == SQRT_LAST) begin
                    r_norm[r_ci] <= r_neg[r_ci] ? (NORM_W'(0) - NORM_W'(root_fin))
                                                : NORM_W'(root_fin);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = (r_state == S_OUT);
    assign o_target_vertex = corner_sel;
    assign o_normal_x      = r_norm[0];
    assign o_normal_y      = r_norm[1];
    assign o_normal_z      = r_norm[2];
    assign o_degenerate    = r_degen;
    assign o_last          = (r_k == LAST_CORNER);

endmodule

>>> design/ffn_checker.sv
// Port-level checker for the face normal engine, bound to the top level.
// Depends on ffn_pkg and flat_face_normal_engine_defines.svh.
`include "flat_face_normal_engine_defines.svh"

module ffn_checker import ffn_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [INDEX_W-1:0]        o_target_vertex,
    input logic signed [NORM_W-1:0]  o_normal_x,
    input logic signed [NORM_W-1:0]  o_normal_y,
    input logic signed [NORM_W-1:0]  o_normal_z,
    input logic                      o_degenerate,
    input logic                      o_last
);

    property p_out_hold;
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_target_vertex)
            && $stable(o_normal_x) && $stable(o_last);
    endproperty

    property p_last_end;
        o_out_valid && o_last && !i_out_stall |=> !o_out_valid;
    endproperty

    property p_degen_zero;
        o_out_valid && o_degenerate |->
            o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0;
    endproperty

    `FFN_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled result changed")
    `FFN_ASSERT(a_busy_out, i_clk, i_rst_n, o_out_valid |-> o_in_stall, "input taken while busy")
    `FFN_ASSERT(a_last_end, i_clk, i_rst_n, p_last_end, "result after last transfer")
    `FFN_ASSERT(a_degen_zero, i_clk, i_rst_n, p_degen_zero, "degenerate normal not zero")
    `FFN_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle")

endmodule

bind flat_face_normal_engine ffn_checker u_ffn_checker (.*);

>>> dv/flat_face_normal_engine_tb.sv
`timescale 1ns / 100ps
// Testbench for flat_face_normal_engine: vertex writes and triangle submits,
// predicted face normals checked per transfer. Depends on ffn_pkg and the engine.
module flat_face_normal_engine_tb;
    import ffn_pkg::*;

    localparam int N_RANDOM    = 100;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic                      command;
        logic [INDEX_W-1:0]        write_index;
        logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
        logic [INDEX_W-1:0]        corner_a, corner_b, corner_c;
    } t_vertex_cmd;

    typedef struct {
        logic [INDEX_W-1:0]       target_vertex;
        logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
        logic                     degenerate;
        logic                     last;
    } t_normal_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_command = 1'b0;
    logic [INDEX_W-1:0] i_write_index = '0;
    logic signed [COORD_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [INDEX_W-1:0] i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [INDEX_W-1:0] o_target_vertex;
    logic signed [NORM_W-1:0] o_normal_x, o_normal_y, o_normal_z;
    logic o_degenerate, o_last;

    flat_face_normal_engine u_dut (.*);

    t_vertex_cmd pending_cmds[$];
    t_normal_res expected_normals[$];
    logic [POS_W-1:0] vertex_positions[1024];
    int total_cmds = 0;
    int sent_cmds = 0;
    int fail_count = 0;
    int cycle_count = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic longint coord(logic [POS_W-1:0] p, int k);
        return longint'($signed(p[k*COORD_W +: COORD_W]));
    endfunction

    function automatic void predict_normals(t_vertex_cmd c);
        logic [POS_W-1:0] pa, pb, pc;
        longint d1[3], d2[3], n[3], m;
        logic [127:0] len2, rhs, t, q;
        logic [NORM_W-1:0] comp[3];
        logic degen;
        t_normal_res r;
        if (c.command == CMD_WRITE) begin
            vertex_positions[c.write_index] = {c.pos_z, c.pos_y, c.pos_x};
            return;
        end
        pa = vertex_positions[c.corner_a];
        pb = vertex_positions[c.corner_b];
        pc = vertex_positions[c.corner_c];
        for (int i = 0; i < 3; i++) begin
            d1[i] = coord(pa, i) - coord(pc, i);
            d2[i] = coord(pa, i) - coord(pb, i);
        end
        n[0] = d1[1] * d2[2] - d1[2] * d2[1];
        n[1] = d1[2] * d2[0] - d1[0] * d2[2];
        n[2] = d1[0] * d2[1] - d1[1] * d2[0];
        len2 = '0;
        for (int i = 0; i < 3; i++) begin
            m = n[i] < 0 ? -n[i] : n[i];
            len2 += 128'(m) * 128'(m);
        end
        degen = (len2 == 0);
        for (int i = 0; i < 3; i++) begin
            m = n[i] < 0 ? -n[i] : n[i];
            q = '0;
            if (!degen) begin
                rhs = (128'(m) * 128'(m)) << 28;
                for (int b = 14; b >= 0; b--) begin
                    t = q | (128'(1) << b);
                    if (t * t * len2 <= rhs)
                        q = t;
                end
            end
            comp[i] = n[i] < 0 ? NORM_W'(-q) : NORM_W'(q);
        end
        for (int k = 0; k < 3; k++) begin
            r.target_vertex = k == 0 ? c.corner_a : (k == 1 ? c.corner_b : c.corner_c);
            r.normal_x = comp[0];
            r.normal_y = comp[1];
            r.normal_z = comp[2];
            r.degenerate = degen;
            r.last = (k == 2);
            expected_normals = {expected_normals, r};
        end
    endfunction

    // idle mix by thirds of the run: sender 33 / receiver 66, swapped, then none
    function automatic int sender_idle_pct();
        if (sent_cmds < total_cmds / 3) return 33;
        if (sent_cmds < 2 * total_cmds / 3) return 66;
        return 0;
    endfunction

    task automatic push_write(int idx, int x, int y, int z, ref bit written[1024],
                              ref int slots[$]);
        t_vertex_cmd c;
        c.command = CMD_WRITE;
        c.write_index = INDEX_W'(idx);
        c.pos_x = COORD_W'(x);
        c.pos_y = COORD_W'(y);
        c.pos_z = COORD_W'(z);
        c.corner_a = INDEX_W'($urandom);
        c.corner_b = INDEX_W'($urandom);
        c.corner_c = INDEX_W'($urandom);
        if (!written[idx]) begin
            written[idx] = 1'b1;
            slots = {slots, idx};
        end
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic push_tri(int a, int b, int cc);
        t_vertex_cmd c;
        c.command = CMD_TRIANGLE;
        c.write_index = INDEX_W'($urandom);
        c.pos_x = COORD_W'($urandom);
        c.pos_y = COORD_W'($urandom);
        c.pos_z = COORD_W'($urandom);
        c.corner_a = INDEX_W'(a);
        c.corner_b = INDEX_W'(b);
        c.corner_c = INDEX_W'(cc);
        pending_cmds = {pending_cmds, c};
    endtask

    // driver
    always @(posedge i_clk) begin
        t_vertex_cmd c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
                c = pending_cmds.pop_front();
                predict_normals(c);
                sent_cmds++;
                i_in_valid    <= 1'b1;
                i_command     <= c.command;
                i_write_index <= c.write_index;
                i_pos_x       <= c.pos_x;
                i_pos_y       <= c.pos_y;
                i_pos_z       <= c.pos_z;
                i_corner_a    <= c.corner_a;
                i_corner_b    <= c.corner_b;
                i_corner_c    <= c.corner_c;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_normal_res e;
        int stall_pct;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_normals.size() == 0) begin
                report_mismatch("unexpected transfer, target", o_target_vertex, -1);
            end else begin
                e = expected_normals.pop_front();
                if (o_target_vertex !== e.target_vertex)
                    report_mismatch("target_vertex", o_target_vertex, e.target_vertex);
                if (o_normal_x !== e.normal_x)
                    report_mismatch("normal_x", o_normal_x, e.normal_x);
                if (o_normal_y !== e.normal_y)
                    report_mismatch("normal_y", o_normal_y, e.normal_y);
                if (o_normal_z !== e.normal_z)
                    report_mismatch("normal_z", o_normal_z, e.normal_z);
                if (o_degenerate !== e.degenerate)
                    report_mismatch("degenerate", o_degenerate, e.degenerate);
                if (o_last !== e.last)
                    report_mismatch("last", o_last, e.last);
            end
        end
        stall_pct = sent_cmds < total_cmds / 3 ? 66 : (sent_cmds < 2 * total_cmds / 3 ? 33 : 0);
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** flat_face_normal_engine: FAILED **");
            $finish;
        end
    end

    initial begin
        bit written[1024];
        int slots[$];
        t_vertex_cmd c;

        // directed: extreme positions, then plain, large, collinear and repeated corners
        push_write(0, 0, 0, 0, written, slots);
        push_write(1023, 32767, 32767, 32767, written, slots);
        push_write(1, -32768, -32768, -32768, written, slots);
        push_write(2, -32768, 0, 0, written, slots);
        push_write(3, 0, 32767, 0, written, slots);
        push_write(4, 0, 0, -32768, written, slots);
        push_write(5, 32767, -32768, 32767, written, slots);
        push_write(6, 100, 0, 0, written, slots);
        push_write(7, 0, 100, 0, written, slots);
        push_tri(0, 6, 7);
        push_tri(7, 6, 0);
        push_tri(2, 3, 4);
        push_tri(4, 3, 2);
        push_tri(5, 1, 1023);
        push_tri(1, 5, 2);
        push_tri(0, 1023, 1);
        push_tri(6, 6, 6);
        push_tri(1023, 0, 1023);
        push_tri(3, 5, 1);

        // random: writes go to random slots, triangles read written slots only
        for (int i = 0; i < N_RANDOM; i++) begin
            c.write_index = INDEX_W'($urandom);
            c.pos_x = COORD_W'($urandom);
            c.pos_y = COORD_W'($urandom);
            c.pos_z = COORD_W'($urandom);
            c.corner_a = INDEX_W'($urandom);
            c.corner_b = INDEX_W'($urandom);
            c.corner_c = INDEX_W'($urandom);
            if ($urandom_range(99) < 45) begin
                c.command = CMD_WRITE;
                if ($urandom_range(9) == 0)
                    c.pos_x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                if (!written[c.write_index]) begin
                    written[c.write_index] = 1'b1;
                    slots = {slots, int'(c.write_index)};
                end
            end else begin
                c.command = CMD_TRIANGLE;
                c.corner_a = INDEX_W'(slots[$urandom_range(slots.size() - 1)]);
                c.corner_b = INDEX_W'(slots[$urandom_range(slots.size() - 1)]);
                c.corner_c = INDEX_W'(slots[$urandom_range(slots.size() - 1)]);
                if ($urandom_range(19) == 0)
                    c.corner_b = c.corner_a;
            end
            pending_cmds = {pending_cmds, c};
        end
        total_cmds = pending_cmds.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_cmds.size() > 0 || i_in_valid || expected_normals.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("** flat_face_normal_engine: PASSED **");
        else
            $display("** flat_face_normal_engine: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/ffn_pkg.sv
design/flat_face_normal_engine.sv
design/ffn_checker.sv
dv/flat_face_normal_engine_tb.sv
